>>> hdl/lfs_pkg.sv
package lfs_pkg;

  // Field widths of the channels and registers.
  localparam int unsigned PixelW = 24;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 17;
  localparam int unsigned OrderW = 3;

  // One pixel with its header spans nine bytes; a bare pixel starts at byte six.
  localparam int unsigned RunBytes = 9;
  localparam int unsigned PosW     = 4;
  localparam logic [PosW-1:0] PosFirst = 4'd0;
  localparam logic [PosW-1:0] PosPixel = 4'd6;
  localparam logic [PosW-1:0] PosLast  = 4'd8;

  // Header constants.
  localparam logic [ByteW-1:0] HdrSyncA = 8'h41;  // 'A'
  localparam logic [ByteW-1:0] HdrSyncD = 8'h64;  // 'd'
  localparam logic [ByteW-1:0] HdrSyncL = 8'h61;  // 'a'
  localparam logic [ByteW-1:0] HdrXor   = 8'h55;

  // Configuration register indexes.
  localparam logic RegLedCount   = 1'b0;
  localparam logic RegColorOrder = 1'b1;

  // Color order codes.
  localparam logic [OrderW-1:0] OrderRgb = 3'd0;
  localparam logic [OrderW-1:0] OrderRbg = 3'd1;
  localparam logic [OrderW-1:0] OrderBrg = 3'd2;
  localparam logic [OrderW-1:0] OrderBgr = 3'd3;
  localparam logic [OrderW-1:0] OrderGrb = 3'd4;
  localparam logic [OrderW-1:0] OrderGbr = 3'd5;

  typedef logic [RunBytes-1:0][ByteW-1:0] run_bytes_t;

  // Bytes caused by one pixel, handed from the frame builder to the emitter.
  typedef struct packed {
    run_bytes_t       bytes;
    logic             header;
    logic             frame_end;
  } run_t;

  // Reorders red, green and blue into wire order; unknown codes send RGB.
  function automatic logic [3*ByteW-1:0] reorder(input logic [PixelW-1:0] color,
                                                 input logic [OrderW-1:0] order);
    logic [ByteW-1:0] r;
    logic [ByteW-1:0] g;
    logic [ByteW-1:0] b;
    logic [3*ByteW-1:0] res;
    r = color[7:0];
    g = color[15:8];
    b = color[23:16];
    unique case (order)
      OrderRbg: res = {g, b, r};
      OrderBrg: res = {g, r, b};
      OrderBgr: res = {r, g, b};
      OrderGrb: res = {b, r, g};
      OrderGbr: res = {r, b, g};
      default:  res = {b, g, r};
    endcase
    return res;
  endfunction

endpackage

>>> hdl/lfs_build.sv
module lfs_build (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [lfs_pkg::PixelW-1:0]        pixel_color,
  input  logic                              last_pixel,
  input  logic [lfs_pkg::CountW-1:0]        led_count,
  input  logic [lfs_pkg::OrderW-1:0]        color_order,
  output logic                              run_valid,
  output lfs_pkg::run_t                     run
);

  logic [lfs_pkg::CountW-1:0] pixel_index;
  logic [lfs_pkg::CountW-1:0] pixel_index_next;
  logic                       dropping;
  logic                       dropping_next;
  logic [lfs_pkg::CountW-1:0] eff_count;
  logic [lfs_pkg::CountW-1:0] count_m1;
  logic [lfs_pkg::CountW-1:0] index_inc;
  logic                       ends;
  logic [3*lfs_pkg::ByteW-1:0] color_bytes;

  // A zero count behaves as a single LED.
  assign eff_count = (led_count == '0) ? lfs_pkg::CountW'(1) : led_count;
  assign count_m1  = eff_count - lfs_pkg::CountW'(1);
  assign index_inc = pixel_index + lfs_pkg::CountW'(1);
  assign ends      = last_pixel || (index_inc >= eff_count);

  assign color_bytes = lfs_pkg::reorder(pixel_color, color_order);

  // Assemble the header and color bytes; a surplus pixel gives no run.
  always_comb begin
    run_valid        = !dropping;
    run.header       = (pixel_index == '0);
    run.frame_end    = ends;
    run.bytes[0]     = lfs_pkg::HdrSyncA;
    run.bytes[1]     = lfs_pkg::HdrSyncD;
    run.bytes[2]     = lfs_pkg::HdrSyncL;
    run.bytes[3]     = count_m1[15:8];
    run.bytes[4]     = count_m1[7:0];
    run.bytes[5]     = count_m1[15:8] ^ count_m1[7:0] ^ lfs_pkg::HdrXor;
    run.bytes[6]     = color_bytes[7:0];
    run.bytes[7]     = color_bytes[15:8];
    run.bytes[8]     = color_bytes[23:16];
  end

  // Frame position and surplus tracking.
  always_comb begin
    pixel_index_next = pixel_index;
    dropping_next    = dropping;
    if (dropping) begin
      if (last_pixel) begin
        dropping_next    = 1'b0;
        pixel_index_next = '0;
      end
    end else if (ends) begin
      pixel_index_next = '0;
      dropping_next    = !last_pixel;
    end else begin
      pixel_index_next = index_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index <= '0;
      dropping    <= 1'b0;
    end else if (accept) begin
      pixel_index <= pixel_index_next;
      dropping    <= dropping_next;
    end
  end

endmodule

>>> hdl/lfs_emit.sv
module lfs_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  lfs_pkg::run_t               run,
  output logic                        take,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lfs_pkg::ByteW-1:0]   m_tdata,
  output logic                        m_tlast,
  output logic                        m_tuser
);

  logic                         buf_valid;
  lfs_pkg::run_bytes_t          buf_bytes;
  logic                         buf_end;
  logic [lfs_pkg::PosW-1:0]     pos;
  logic                         move;
  logic                         at_last;

  // A byte moves into the output register whenever that register frees up.
  assign move    = buf_valid && (!m_tvalid || m_tready);
  assign at_last = (pos == lfs_pkg::PosLast);
  assign take    = !buf_valid || (move && at_last);

  // Run buffer: holds the bytes of one pixel until all are sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      pos       <= lfs_pkg::PosFirst;
    end else if (load) begin
      buf_valid <= 1'b1;
      pos       <= run.header ? lfs_pkg::PosFirst : lfs_pkg::PosPixel;
    end else if (move) begin
      buf_valid <= !at_last;
      pos       <= pos + lfs_pkg::PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_bytes <= run.bytes;
      buf_end   <= run.frame_end;
    end
  end

  // Output register of the master side.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      m_tdata <= buf_bytes[pos];
      m_tlast <= at_last;
      m_tuser <= at_last && buf_end;
    end
  end

endmodule

>>> hdl/led_strip_frame_serializer.sv
// LED strip frame serializer.
// Slave side: one transfer per pixel; s_tdata carries the color (red 7:0,
// green 15:8, blue 23:16) and s_tlast marks the final pixel of a frame.
// Master side: one transfer per frame byte on m_tdata; m_tlast marks the last
// byte caused by a pixel, m_tuser the last byte of the frame.
// The first pixel of a frame yields nine bytes (six header bytes and three
// color bytes), every other pixel three; pixels past led_count give nothing
// until the next s_tlast.
// The first byte of a pixel passes from the run buffer into the output register.
// The master side moves one byte per cycle while m_tready stays high; the
// one-byte output port sets that rate. Surplus pixels are taken one per cycle
// while the run buffer is empty.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 led_count,
// 1 color_order); write only while the block is idle.
// Reset clears the frame position and both registers to led_count 1 and RGB.
// When the receiver stalls, the output holds its byte and s_tready drops once
// the run buffer holds bytes that cannot move on.
module led_strip_frame_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lfs_pkg::PixelW-1:0]    s_tdata,   // pixel_color [23:0]
  input  logic                          s_tlast,   // last_pixel
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lfs_pkg::ByteW-1:0]     m_tdata,   // out_byte [7:0]
  output logic                          m_tlast,   // last_of_run
  output logic                          m_tuser,   // frame_end [0]
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [lfs_pkg::CountW-1:0]    cfg_data
);

  logic [lfs_pkg::CountW-1:0] led_count;
  logic [lfs_pkg::OrderW-1:0] color_order;
  logic                       accept;
  logic                       run_valid;
  lfs_pkg::run_t              run;
  logic                       take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count   <= lfs_pkg::CountW'(1);
      color_order <= lfs_pkg::OrderRgb;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfs_pkg::RegLedCount:   led_count   <= cfg_data;
        lfs_pkg::RegColorOrder: color_order <= cfg_data[lfs_pkg::OrderW-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = take;
  assign accept   = s_tvalid && take;

  lfs_build u_build (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel_color (s_tdata),
    .last_pixel  (s_tlast),
    .led_count   (led_count),
    .color_order (color_order),
    .run_valid   (run_valid),
    .run         (run)
  );

  lfs_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && run_valid),
    .run      (run),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

>>> hdl/lfs_checker.sv
module lfs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [lfs_pkg::ByteW-1:0]     m_tdata,
  input logic                          m_tlast,
  input logic                          m_tuser
);

  // A stalled output byte holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled output byte changed");

  // The end of a frame is always the last byte of a pixel.
  a_end_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end without run end");

  // Reset leaves no byte pending and the slave side open.
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind led_strip_frame_serializer lfs_checker u_lfs_checker (.*);

>>> tb/led_strip_frame_serializer_tb.sv
module led_strip_frame_serializer_tb;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned MaxReports   = 10;

  // One expected byte of the serial frame with its two markers.
  typedef struct packed {
    logic [lfs_pkg::ByteW-1:0] value;
    logic                      run_end;
    logic                      frame_end;
  } frame_byte_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [lfs_pkg::PixelW-1:0]   s_tdata = '0;
  logic                         s_tlast = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [lfs_pkg::ByteW-1:0]    m_tdata;
  logic                         m_tlast;
  logic                         m_tuser;
  logic                         cfg_we = 1'b0;
  logic                         cfg_index = lfs_pkg::RegLedCount;
  logic [lfs_pkg::CountW-1:0]   cfg_data = '0;

  // Predictor state: registers and frame position as the block should hold them.
  logic [lfs_pkg::CountW-1:0]   strip_length = 17'd1;
  logic [lfs_pkg::OrderW-1:0]   wire_order = lfs_pkg::OrderRgb;
  logic [lfs_pkg::CountW-1:0]   pixels_in_frame = '0;
  logic                         skipping_surplus = 1'b0;
  frame_byte_t                  pending_bytes[$];

  int unsigned         mismatches = 0;
  int unsigned         pixels_out = 0;
  int unsigned         pixels_dropped = 0;
  int unsigned         bytes_checked = 0;
  int unsigned         config_writes = 0;
  int unsigned         quiet_cycles = 0;
  logic                no_gaps = 1'b0;
  logic                stall_request = 1'b0;

  led_strip_frame_serializer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // pixel_color [23:0]
    .s_tlast   (s_tlast),   // last_pixel
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // out_byte [7:0]
    .m_tlast   (m_tlast),   // last_of_run
    .m_tuser   (m_tuser),   // frame_end [0]
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%s", msg);
    end
  endtask

  // Works out the bytes one accepted pixel causes and queues them.
  task automatic serialize_pixel(input logic [lfs_pkg::PixelW-1:0] color, input logic last);
    logic [lfs_pkg::ByteW-1:0]  red;
    logic [lfs_pkg::ByteW-1:0]  green;
    logic [lfs_pkg::ByteW-1:0]  blue;
    logic [lfs_pkg::ByteW-1:0]  hi;
    logic [lfs_pkg::ByteW-1:0]  lo;
    logic [lfs_pkg::CountW-1:0] eff;
    logic [lfs_pkg::CountW-1:0] span;
    logic [lfs_pkg::ByteW-1:0]  run[$];
    logic                       done;
    frame_byte_t                item;
    red   = color[7:0];
    green = color[15:8];
    blue  = color[23:16];
    eff   = strip_length;
    if (eff == '0) begin
      eff = 17'd1;
    end
    if (skipping_surplus) begin
      // Surplus pixels vanish; the one marked last readies the next frame.
      pixels_dropped++;
      if (last) begin
        skipping_surplus = 1'b0;
        pixels_in_frame  = '0;
      end
    end else begin
      if (pixels_in_frame == '0) begin
        span = eff - 1'b1;
        hi   = span[15:8];
        lo   = span[7:0];
        run = {run, lfs_pkg::HdrSyncA, lfs_pkg::HdrSyncD, lfs_pkg::HdrSyncL,
               hi, lo, hi ^ lo ^ lfs_pkg::HdrXor};
      end
      case (wire_order)
        lfs_pkg::OrderRbg: run = {run, red, blue, green};
        lfs_pkg::OrderBrg: run = {run, blue, red, green};
        lfs_pkg::OrderBgr: run = {run, blue, green, red};
        lfs_pkg::OrderGrb: run = {run, green, red, blue};
        lfs_pkg::OrderGbr: run = {run, green, blue, red};
        default:           run = {run, red, green, blue};
      endcase
      pixels_in_frame = pixels_in_frame + 1'b1;
      done = last || (pixels_in_frame >= eff);
      foreach (run[i]) begin
        item.value     = run[i];
        item.run_end   = (i == run.size() - 1);
        item.frame_end = item.run_end && done;
        pending_bytes  = {pending_bytes, item};
      end
      if (done) begin
        pixels_in_frame  = '0;
        skipping_surplus = !last;
      end
      pixels_out++;
    end
  endtask

  // Offers one pixel after a random gap and waits for its transfer.
  task automatic send_pixel(input logic [lfs_pkg::PixelW-1:0] color, input logic last);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= color;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    serialize_pixel(color, last);
  endtask

  task automatic write_register(input logic index, input logic [lfs_pkg::CountW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == lfs_pkg::RegLedCount) begin
      strip_length = value;
    end else begin
      wire_order = value[lfs_pkg::OrderW-1:0];
    end
    config_writes++;
    @(posedge clk);
  endtask

  // Stops offering, lets every expected byte arrive, then lets surplus pixels settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Reset values: one LED, RGB. A pixel without last ends the frame and
  // later pixels are dropped until one marked last.
  task automatic test_reset_state();
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h123456, 1'b1);
    send_pixel(24'hA5A5A5, 1'b1);
    wait_idle();
  endtask

  // Every color order code, including the two unknown ones that fall back to RGB.
  task automatic test_color_orders();
    write_register(lfs_pkg::RegLedCount, 17'd1);
    for (int order = 0; order < 8; order++) begin
      write_register(lfs_pkg::RegColorOrder, lfs_pkg::CountW'(order));
      send_pixel(24'hC35A96 ^ lfs_pkg::PixelW'(order << 4), 1'b1);
      wait_idle();
    end
  endtask

  // Zero count acts as one; the header keeps only bits 15:0 of the count minus one.
  task automatic test_count_extremes();
    write_register(lfs_pkg::RegColorOrder, lfs_pkg::CountW'(lfs_pkg::OrderRgb));
    write_register(lfs_pkg::RegLedCount, 17'd0);
    send_pixel(24'h000000, 1'b1);
    wait_idle();
    write_register(lfs_pkg::RegLedCount, 17'd65536);
    send_pixel(24'hFFFFFF, 1'b1);
    wait_idle();
    write_register(lfs_pkg::RegLedCount, 17'd70000);
    send_pixel(24'h0F0F0F, 1'b1);
    wait_idle();
    write_register(lfs_pkg::RegLedCount, 17'h1FFFF);
    send_pixel(24'hF0F0F0, 1'b1);
    wait_idle();
  endtask

  // More pixels than LEDs: the extras give nothing up to the one marked last.
  task automatic test_surplus_pixels();
    write_register(lfs_pkg::RegLedCount, 17'd2);
    write_register(lfs_pkg::RegColorOrder, lfs_pkg::CountW'(lfs_pkg::OrderBgr));
    send_pixel(24'h010203, 1'b0);
    send_pixel(24'h040506, 1'b0);
    send_pixel(24'h070809, 1'b0);
    send_pixel(24'h0A0B0C, 1'b1);
    wait_idle();
  endtask

  // The count drops below the frame position between pixels; the next pixel ends it.
  task automatic test_count_lowered();
    write_register(lfs_pkg::RegLedCount, 17'd5);
    send_pixel(24'h111111, 1'b0);
    send_pixel(24'h222222, 1'b0);
    send_pixel(24'h333333, 1'b0);
    wait_idle();
    write_register(lfs_pkg::RegLedCount, 17'd2);
    send_pixel(24'h444444, 1'b0);
    send_pixel(24'h555555, 1'b1);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while pixels keep coming.
  task automatic test_backpressure();
    write_register(lfs_pkg::RegLedCount, 17'd40);
    write_register(lfs_pkg::RegColorOrder, lfs_pkg::CountW'(lfs_pkg::OrderGrb));
    stall_request = 1'b1;
    for (int i = 0; i < 25; i++) begin
      send_pixel(lfs_pkg::PixelW'($urandom()), i == 24);
    end
    wait_idle();
  endtask

  // Random strip settings, each followed by a burst of frames.
  task automatic test_random_frames(input int unsigned pixels_wanted);
    int unsigned goal;
    int unsigned sel;
    int unsigned eff;
    int unsigned frames;
    int unsigned len;
    int unsigned len_cap;
    logic [lfs_pkg::CountW-1:0] count;
    goal = pixels_out + pixels_dropped + pixels_wanted;
    while (pixels_out + pixels_dropped < goal) begin
      wait_idle();
      sel = $urandom_range(0, 9);
      case (sel)
        0:       count = '0;
        1:       count = 17'd65536;
        2:       count = lfs_pkg::CountW'($urandom_range(65537, 131071));
        3:       count = lfs_pkg::CountW'($urandom_range(9, 65535));
        default: count = lfs_pkg::CountW'($urandom_range(1, 8));
      endcase
      write_register(lfs_pkg::RegLedCount, count);
      write_register(lfs_pkg::RegColorOrder, lfs_pkg::CountW'($urandom_range(0, 7)));
      no_gaps = ($urandom_range(0, 3) == 0);
      eff     = (count == '0) ? 1 : 32'(count);
      len_cap = (eff + 2 > 12) ? 12 : eff + 2;
      frames  = $urandom_range(2, 6);
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(0, 7) == 0) begin
          // Noise: last marks at random, which may leave a frame open.
          len = $urandom_range(1, 6);
          for (int p = 0; p < len; p++) begin
            send_pixel(lfs_pkg::PixelW'($urandom()), 1'($urandom_range(0, 1)));
          end
        end else begin
          // Well-formed frame, possibly longer than the strip.
          len = $urandom_range(1, len_cap);
          for (int p = 0; p < len; p++) begin
            send_pixel(lfs_pkg::PixelW'($urandom()), p == len - 1);
          end
        end
      end
    end
    no_gaps = 1'b0;
    wait_idle();
  endtask

  // Receiver: random ready gaps per byte, and one long hold-off on request.
  initial begin : byte_sink
    int unsigned gap;
    @(negedge rst);
    forever begin
      if (stall_request) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        stall_request = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  // Compares every byte transfer with the oldest expected byte.
  always @(posedge clk) begin : check_bytes
    frame_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h last %0b end %0b",
                             m_tdata, m_tlast, m_tuser));
      end else begin
        want = pending_bytes.pop_front();
        if (m_tdata !== want.value || m_tlast !== want.run_end ||
            m_tuser !== want.frame_end) begin
          flag_error($sformatf(
            "mismatch: expected byte %02h last %0b end %0b, got byte %02h last %0b end %0b",
            want.value, want.run_end, want.frame_end, m_tdata, m_tlast, m_tuser));
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer or write happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_color_orders();
    test_count_extremes();
    test_surplus_pixels();
    test_count_lowered();
    test_backpressure();
    test_random_frames(250);
    repeat (20) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      flag_error($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
    end
    $display("Sent %0d pixels into frames and %0d surplus pixels, under %0d register writes.",
             pixels_out, pixels_dropped, config_writes);
    $display("Checked %0d frame bytes; %0d mismatches.", bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
